[design/tmds_pkg.sv]
`default_nettype none

package tmds_pkg;

    // Item actions
    typedef enum logic [2:0] {
        ACT_LOAD      = 3'd0,
        ACT_UP_CHG    = 3'd1,
        ACT_UP_VAL    = 3'd2,
        ACT_RIGHT_CHG = 3'd3,
        ACT_RIGHT_VAL = 3'd4,
        ACT_DOWN_CHG  = 3'd5,
        ACT_DOWN_VAL  = 3'd6,
        ACT_READ      = 3'd7
    } t_action;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

    localparam logic [2:0] WIDTH_LOG2_RST = 3'd6;
    localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;

    typedef struct packed {
        logic [2:0] action;
        logic [5:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] data_value;
    } t_item;

    typedef struct packed {
        logic       found;
        logic [6:0] stop_coord;
        logic [7:0] pixel_out;
    } t_result;

endpackage

`default_nettype wire

[design/tmds_ifs.sv]
`default_nettype none

// Input item channel
interface tmds_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [5:0] pos_x;
    logic [6:0] pos_y;
    logic [7:0] data_value;

    modport source (output valid, action, pos_x, pos_y, data_value, input ready);
    modport sink   (input valid, action, pos_x, pos_y, data_value, output ready);
endinterface

// Result item channel
interface tmds_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [6:0] stop_coord;
    logic [7:0] pixel_out;

    modport source (output valid, found, stop_coord, pixel_out, input ready);
    modport sink   (input valid, found, stop_coord, pixel_out, output ready);
endinterface

// Configuration write channel
interface tmds_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/tmds_ram.sv]
`default_nettype none

module tmds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_addr,
    input  wire  [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

[design/tmds_engine.sv]
`default_nettype none

module tmds_engine import tmds_pkg::*; #(
    parameter int MAX_WIDTH_LOG2 = 6,
    parameter int STORE_DEPTH    = 8192
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_item_valid,
    output logic                           o_item_ready,
    input  wire  t_item                    i_item,
    input  wire  [2:0]                     i_width_log2,
    input  wire  [6:0]                     i_map_height,
    output logic                           o_ram_we,
    output logic [$clog2(STORE_DEPTH)-1:0] o_ram_addr,
    output logic [7:0]                     o_ram_wdata,
    input  wire  [7:0]                     i_ram_rdata,
    output logic                           o_res_valid,
    input  wire                            i_res_ready,
    output t_result                        o_res
);

    localparam int AW   = $clog2(STORE_DEPTH);
    localparam int EW   = $clog2(MAX_WIDTH_LOG2 + 1);
    localparam int WW   = MAX_WIDTH_LOG2 + 1;
    localparam int CXW  = (MAX_WIDTH_LOG2 > 6) ? MAX_WIDTH_LOG2 : 6;
    localparam int CW   = CXW + 2;
    localparam int FA_W = MAX_WIDTH_LOG2 + 8;
    localparam int CMPW = ((FA_W > AW) ? FA_W : AW) + 1;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(STORE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FIRST = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    t_action         r_action, n_action;
    logic [CXW-1:0]  r_cx, n_cx;
    logic [6:0]      r_cy, n_cy;
    logic [7:0]      r_val, n_val;
    logic [7:0]      r_start, n_start;
    logic            r_inside, n_inside;
    logic            r_oob;
    t_result         r_res, n_res;

    logic [EW-1:0]   eff;
    logic [WW-1:0]   map_w;
    logic            accept;
    logic            in_inside;
    logic            is_up, is_right, is_down, by_value;
    logic            at_edge;
    logic [CXW-1:0]  stp_cx;
    logic [6:0]      stp_cy;
    logic [CXW-1:0]  rd_x;
    logic [6:0]      rd_y;
    logic [FA_W-1:0] rd_full;
    logic            rd_ok;
    logic [7:0]      pix;
    logic            hit;

    // Saturate the width exponent and form the map width
    always_comb begin
        if (32'(i_width_log2) > MAX_WIDTH_LOG2) begin
            eff = EW'(MAX_WIDTH_LOG2);
        end else begin
            eff = EW'(i_width_log2);
        end
        map_w = WW'(1) << eff;
    end

    assign o_item_ready = (r_state == ST_IDLE);
    assign accept       = i_item_valid && o_item_ready;
    assign in_inside    = (CW'(i_item.pos_x) < CW'(map_w)) && (i_item.pos_y < i_map_height);

    // Decode scan direction and kind
    always_comb begin
        is_up    = 1'b0;
        is_right = 1'b0;
        is_down  = 1'b0;
        by_value = 1'b0;
        case (r_action) inside
            ACT_UP_CHG, ACT_UP_VAL:       is_up    = 1'b1;
            ACT_RIGHT_CHG, ACT_RIGHT_VAL: is_right = 1'b1;
            ACT_DOWN_CHG, ACT_DOWN_VAL:   is_down  = 1'b1;
            default:                      is_up    = 1'b0;
        endcase
        case (r_action) inside
            ACT_UP_VAL, ACT_RIGHT_VAL, ACT_DOWN_VAL: by_value = 1'b1;
            default:                                 by_value = 1'b0;
        endcase
    end

    // Edge test and the coordinate one step on
    always_comb begin
        at_edge = 1'b0;
        stp_cx  = r_cx;
        stp_cy  = r_cy;
        if (is_up) begin
            at_edge = (r_cy == 7'd0);
            stp_cy  = r_cy - 7'd1;
        end else if (is_right) begin
            at_edge = (CW'(r_cx) + CW'(1)) >= CW'(map_w);
            stp_cx  = r_cx + CXW'(1);
        end else if (is_down) begin
            at_edge = ({1'b0, r_cy} + 8'd1) >= {1'b0, i_map_height};
            stp_cy  = r_cy + 7'd1;
        end
    end

    // Read address: the new item in idle, else the next scan pixel
    always_comb begin
        if (r_state == ST_IDLE) begin
            rd_x = CXW'(i_item.pos_x);
            rd_y = i_item.pos_y;
        end else begin
            rd_x = stp_cx;
            rd_y = stp_cy;
        end
        rd_full = (FA_W'(rd_y) << eff) + FA_W'(rd_x);
        rd_ok   = CMPW'(rd_full) < DEPTH_C;
    end

    assign o_ram_addr  = AW'(rd_full);
    assign o_ram_wdata = i_item.data_value;
    assign o_ram_we    = accept && (t_action'(i_item.action) == ACT_LOAD) && in_inside && rd_ok;

    // Pixel beyond the store reads as zero
    assign pix = r_oob ? 8'd0 : i_ram_rdata;
    assign hit = by_value ? (pix == r_val) : (pix != r_start);

    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_val    = r_val;
        n_start  = r_start;
        n_inside = r_inside;
        n_res    = r_res;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (t_action'(i_item.action) != ACT_LOAD)) begin
                    n_action = t_action'(i_item.action);
                    n_cx     = CXW'(i_item.pos_x);
                    n_cy     = i_item.pos_y;
                    n_val    = i_item.data_value;
                    n_inside = in_inside;
                    n_state  = ST_FIRST;
                end
            end
            ST_FIRST: begin
                n_start = pix;
                n_res   = '0;
                if (r_action == ACT_READ) begin
                    n_res.found     = 1'b1;
                    n_res.pixel_out = r_inside ? pix : 8'd0;
                    n_state         = ST_DONE;
                end else if (!r_inside || at_edge) begin
                    n_state = ST_DONE;
                end else begin
                    n_cx    = stp_cx;
                    n_cy    = stp_cy;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_res = '0;
                if (hit) begin
                    n_res.found      = 1'b1;
                    n_res.stop_coord = is_right ? 7'(r_cx) : r_cy;
                    n_res.pixel_out  = pix;
                    n_state          = ST_DONE;
                end else if (at_edge) begin
                    n_state = ST_DONE;
                end else begin
                    n_cx = stp_cx;
                    n_cy = stp_cy;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_action <= n_action;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_val    <= n_val;
        r_start  <= n_start;
        r_inside <= n_inside;
        r_res    <= n_res;
        r_oob    <= !rd_ok;
    end

endmodule

`default_nettype wire

[design/tile_map_directional_scan.sv]
// Load item: written to the pixel store in the cycle it is accepted, no result.
// Read item: result passes from the engine's done state into the output register.
// Scan item: steps N pixels after the first read (up to a row or column, 126 at most),
//   one pixel store read per cycle; a new item is taken once the result is handed on.
// Reset clears the control state and sets width_log2 to 6 and map_height to 64;
//   the pixel store is not cleared and holds nothing defined until loaded.
`default_nettype none

module tile_map_directional_scan import tmds_pkg::*; #(
    parameter int MAX_WIDTH_LOG2 = 6,
    parameter int STORE_DEPTH    = 8192
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    tmds_item_if.sink     i_item,
    tmds_result_if.source o_result,
    tmds_cfg_if.sink      i_cfg
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [2:0]    r_width_log2;
    logic [6:0]    r_map_height;
    logic          r_out_valid;
    t_result       r_out;

    t_item         item;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic          res_valid;
    logic          res_ready;
    t_result       res;

    // Configuration registers, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2 <= WIDTH_LOG2_RST;
            r_map_height <= MAP_HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WIDTH_LOG2: r_width_log2 <= i_cfg.data[2:0];
                CFG_MAP_HEIGHT: r_map_height <= i_cfg.data;
                default:        r_width_log2 <= r_width_log2;
            endcase
        end
    end

    assign item.action     = i_item.action;
    assign item.pos_x      = i_item.pos_x;
    assign item.pos_y      = i_item.pos_y;
    assign item.data_value = i_item.data_value;

    tmds_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    tmds_engine #(
        .MAX_WIDTH_LOG2 (MAX_WIDTH_LOG2),
        .STORE_DEPTH    (STORE_DEPTH)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (i_item.ready),
        .i_item       (item),
        .i_width_log2 (r_width_log2),
        .i_map_height (r_map_height),
        .o_ram_we     (ram_we),
        .o_ram_addr   (ram_addr),
        .o_ram_wdata  (ram_wdata),
        .i_ram_rdata  (ram_rdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // Output register: take a result when empty or being drained
    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.found      = r_out.found;
    assign o_result.stop_coord = r_out.stop_coord;
    assign o_result.pixel_out  = r_out.pixel_out;

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tmds_pkg::*;

    localparam int MAP_SHIFT_MAX = 6;
    localparam int STORE_WORDS   = 8192;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 150;
    localparam int LONG_HOLD     = 400;
    localparam int N_DIRECTED    = 25;
    localparam int N_SETTINGS    = 11;
    localparam int MAX_REPORTS   = 10;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        t_item   it;
        logic    typed;
        t_result want;
    } t_dir_row;

    typedef struct packed {
        logic [2:0] wlog2;
        logic [6:0] height;
        logic [7:0] n_items;
    } t_map_setting;

    // Directed rows, run with the reset map (64 x 64, nothing loaded yet)
    localparam t_dir_row DIR_TBL [N_DIRECTED] = '{
        '{'{ACT_READ,      6'd0,  7'd64,  8'h00}, 1'b1, '{1'b1, 7'd0,  8'h00}},
        '{'{ACT_READ,      6'd63, 7'd127, 8'hFF}, 1'b1, '{1'b1, 7'd0,  8'h00}},
        '{'{ACT_UP_CHG,    6'd10, 7'd100, 8'h00}, 1'b1, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_RIGHT_VAL, 6'd63, 7'd127, 8'hFF}, 1'b1, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd5,  7'd70,  8'h12}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd61, 7'd0,   8'hAA}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd62, 7'd0,   8'h55}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd63, 7'd0,   8'hFF}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_READ,      6'd63, 7'd0,   8'h00}, 1'b1, '{1'b1, 7'd0,  8'hFF}},
        '{'{ACT_RIGHT_CHG, 6'd61, 7'd0,   8'h00}, 1'b1, '{1'b1, 7'd62, 8'h55}},
        '{'{ACT_RIGHT_VAL, 6'd61, 7'd0,   8'hFF}, 1'b1, '{1'b1, 7'd63, 8'hFF}},
        '{'{ACT_RIGHT_CHG, 6'd63, 7'd0,   8'h00}, 1'b1, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_RIGHT_VAL, 6'd62, 7'd0,   8'h00}, 1'b1, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd0,  7'd0,   8'h00}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd0,  7'd1,   8'h00}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd0,  7'd2,   8'h80}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_DOWN_CHG,  6'd0,  7'd0,   8'h00}, 1'b1, '{1'b1, 7'd2,  8'h80}},
        '{'{ACT_DOWN_VAL,  6'd0,  7'd0,   8'h80}, 1'b1, '{1'b1, 7'd2,  8'h80}},
        '{'{ACT_UP_CHG,    6'd0,  7'd2,   8'h00}, 1'b1, '{1'b1, 7'd1,  8'h00}},
        '{'{ACT_UP_VAL,    6'd0,  7'd2,   8'h00}, 1'b1, '{1'b1, 7'd1,  8'h00}},
        '{'{ACT_UP_CHG,    6'd0,  7'd0,   8'h00}, 1'b1, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_LOAD,      6'd0,  7'd63,  8'h11}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_DOWN_CHG,  6'd0,  7'd63,  8'h00}, 1'b1, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_READ,      6'd62, 7'd0,   8'h00}, 1'b0, '{1'b0, 7'd0,  8'h00}},
        '{'{ACT_RIGHT_CHG, 6'd62, 7'd0,   8'h00}, 1'b0, '{1'b0, 7'd0,  8'h00}}
    };

    // Map settings for the random part: width_log2, map_height, items
    localparam t_map_setting MAP_SETTINGS [N_SETTINGS] = '{
        '{3'd6, 7'd64,  8'd80},
        '{3'd3, 7'd8,   8'd60},
        '{3'd3, 7'd15,  8'd60},
        '{3'd0, 7'd1,   8'd30},
        '{3'd1, 7'd3,   8'd60},
        '{3'd7, 7'd127, 8'd70},
        '{3'd0, 7'd0,   8'd20},
        '{3'd2, 7'd127, 8'd60},
        '{3'd4, 7'd20,  8'd60},
        '{3'd5, 7'd40,  8'd60},
        '{3'd2, 7'd5,   8'd60}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tmds_item_if   item_ch ();
    tmds_result_if result_ch ();
    tmds_cfg_if    cfg_ch ();

    tile_map_directional_scan uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_result(result_ch),
        .i_cfg   (cfg_ch)
    );

    // Mirror of the pixel store and the registers
    bit   [7:0] map_mirror [STORE_WORDS];
    bit         map_loaded [STORE_WORDS];
    logic [2:0] cur_wlog2  = WIDTH_LOG2_RST;
    logic [6:0] cur_height = MAP_HEIGHT_RST;
    t_result    pending_results [$];

    int n_errors   = 0;
    int n_items    = 0;
    int n_loads    = 0;
    int n_scans    = 0;
    int n_reads    = 0;
    int n_results  = 0;
    int n_found    = 0;
    int n_settings = 0;
    bit steady     = 1'b0;
    bit hold_req   = 1'b0;

    // Window of the map the random items mostly land in
    int         win_x0, win_y0, win_w, win_h;
    logic [7:0] palette [3];

    always #5ns i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 16);
        return $urandom_range(30, 120);
    endfunction

    // Effective width exponent; wider settings saturate
    function automatic int map_shift();
        return (int'(cur_wlog2) > MAP_SHIFT_MAX) ? MAP_SHIFT_MAX : int'(cur_wlog2);
    endfunction

    // Fetch one pixel and note the first never-loaded address touched
    function automatic logic [7:0] peek_pixel(int x, int y, inout int blank);
        int addr;
        addr = (y << map_shift()) + x;
        if (addr >= STORE_WORDS) return 8'h00;
        if (!map_loaded[addr] && blank < 0) blank = addr;
        return map_mirror[addr];
    endfunction

    // Work out a scan or read; blank gets the first never-loaded address
    // the walk touches, -1 if none
    function automatic t_result walk_map(t_item it, output int blank);
        t_result    res;
        t_action    act;
        int         w, h, cx, cy;
        bit         by_value, done;
        logic [7:0] start_px, px;
        act   = t_action'(it.action);
        w     = 1 << map_shift();
        h     = int'(cur_height);
        res   = '0;
        blank = -1;
        if (int'(it.pos_x) >= w || int'(it.pos_y) >= h) begin
            res.found = (act == ACT_READ);
            return res;
        end
        if (act == ACT_LOAD) return res;
        if (act == ACT_READ) begin
            res.found     = 1'b1;
            res.pixel_out = peek_pixel(it.pos_x, it.pos_y, blank);
            return res;
        end
        by_value = (act == ACT_UP_VAL) || (act == ACT_RIGHT_VAL) || (act == ACT_DOWN_VAL);
        start_px = peek_pixel(it.pos_x, it.pos_y, blank);
        cx       = it.pos_x;
        cy       = it.pos_y;
        done     = 1'b0;
        // step toward the edge until a hit or the edge itself
        while (!done) begin
            case (act)
                ACT_UP_CHG, ACT_UP_VAL: begin
                    if (cy == 0) done = 1'b1;
                    else cy--;
                end
                ACT_RIGHT_CHG, ACT_RIGHT_VAL: begin
                    if (cx + 1 >= w) done = 1'b1;
                    else cx++;
                end
                default: begin
                    if (cy + 1 >= h) done = 1'b1;
                    else cy++;
                end
            endcase
            if (!done) begin
                px = peek_pixel(cx, cy, blank);
                if (by_value ? (px == it.data_value) : (px != start_px)) begin
                    res.found      = 1'b1;
                    res.stop_coord = (act == ACT_RIGHT_CHG || act == ACT_RIGHT_VAL) ?
                                     7'(cx) : 7'(cy);
                    res.pixel_out  = px;
                    done           = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // Fold an accepted item into the mirror and queue the result it owes
    function automatic void absorb_item(t_item it, logic typed, t_result want);
        int      blank, addr;
        t_result res;
        if (t_action'(it.action) == ACT_LOAD) begin
            addr = (int'(it.pos_y) << map_shift()) + it.pos_x;
            if (int'(it.pos_x) < (1 << map_shift()) && int'(it.pos_y) < int'(cur_height)
                    && addr < STORE_WORDS) begin
                map_mirror[addr] = it.data_value;
                map_loaded[addr] = 1'b1;
                n_loads++;
                n_items++;
            end
            return;
        end
        res = walk_map(it, blank);
        pending_results.push_back(typed ? want : res);
        n_items++;
        if (t_action'(it.action) == ACT_READ) n_reads++;
        else n_scans++;
    endfunction

    // Random item; a walk that would touch a never-loaded pixel becomes
    // a load of that pixel, so the map fills along the paths in use
    function automatic t_item draw_item();
        t_item   it;
        t_result unused;
        int      roll, w, h, blank;
        w    = 1 << map_shift();
        h    = int'(cur_height);
        roll = $urandom_range(0, 99);
        if (roll < 35) it.action = ACT_LOAD;
        else if (roll < 45) it.action = ACT_READ;
        else it.action = 3'($urandom_range(int'(ACT_UP_CHG), int'(ACT_DOWN_VAL)));
        if (h == 0 || $urandom_range(0, 99) < 10) begin
            if (w < 64 && $urandom_range(0, 1) == 1) begin
                it.pos_x = 6'($urandom_range(w, 63));
                it.pos_y = 7'($urandom_range(0, 127));
            end else begin
                it.pos_x = 6'($urandom_range(0, 63));
                it.pos_y = 7'($urandom_range(h, 127));
            end
        end else begin
            it.pos_x = 6'(win_x0 + $urandom_range(0, win_w - 1));
            it.pos_y = 7'(win_y0 + $urandom_range(0, win_h - 1));
        end
        if ($urandom_range(0, 3) == 0) it.data_value = 8'($urandom_range(0, 255));
        else it.data_value = palette[$urandom_range(0, 2)];
        if (t_action'(it.action) != ACT_LOAD) begin
            unused = walk_map(it, blank);
            if (blank >= 0) begin
                it.action     = ACT_LOAD;
                it.pos_x      = 6'(blank & (w - 1));
                it.pos_y      = 7'(blank >> map_shift());
                it.data_value = palette[$urandom_range(0, 2)];
            end
        end
        return it;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic offer_item(t_item it, logic typed = 1'b0, t_result want = '0);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid      <= 1'b1;
        item_ch.action     <= it.action;
        item_ch.pos_x      <= it.pos_x;
        item_ch.pos_y      <= it.pos_y;
        item_ch.data_value <= it.data_value;
        do @(posedge i_clk); while (!item_ch.ready);
        absorb_item(it, typed, want);
    endtask

    // Drop valid on the item channel
    task automatic pause_items();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every owed result, then let a trailing load land
    task automatic settle_block();
        pause_items();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register and track it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_WIDTH_LOG2: cur_wlog2  = data[2:0];
            CFG_MAP_HEIGHT: cur_height = data[6:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result(t_result got);
        t_result want;
        n_results++;
        if (got.found === 1'b1) n_found++;
        if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("ERROR: unexpected result found=%0b coord=%0d pixel=%02h",
                         got.found, got.stop_coord, got.pixel_out);
            return;
        end
        want = pending_results.pop_front();
        if (got.found !== want.found || got.stop_coord !== want.stop_coord
                || got.pixel_out !== want.pixel_out) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("ERROR: result %0d: expected found=%0b coord=%0d pixel=%02h, %s",
                         n_results, want.found, want.stop_coord, want.pixel_out,
                         $sformatf("got found=%0b coord=%0d pixel=%02h",
                                   got.found, got.stop_coord, got.pixel_out));
        end
    endtask

    // Result side: random stalls, steady stretches and one long hold
    initial begin : result_sink
        int      stall_left, run_left, hold_left;
        t_result got;
        stall_left      = 0;
        run_left        = 0;
        hold_left       = 0;
        result_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
                got = {result_ch.found, result_ch.stop_coord, result_ch.pixel_out};
                check_result(got);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else if (steady) begin
                result_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                result_ch.ready <= 1'b1;
            end else begin
                run_left   = $urandom_range(1, 8);
                stall_left = idle_len();
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Item side: reset, directed table, then random items per map setting
    initial begin : stimulus
        t_map_setting ms;
        int           target, k, w, h;
        item_ch.valid      <= 1'b0;
        item_ch.action     <= ACT_LOAD;
        item_ch.pos_x      <= '0;
        item_ch.pos_y      <= '0;
        item_ch.data_value <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_WIDTH_LOG2;
        cfg_ch.data        <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++)
            offer_item(DIR_TBL[r].it, DIR_TBL[r].typed, DIR_TBL[r].want);

        for (int s = 0; s < N_SETTINGS; s++) begin
            ms = MAP_SETTINGS[s];
            settle_block();
            // upper data bits are don't-care for the width register
            write_reg(CFG_WIDTH_LOG2, {4'($urandom_range(0, 15)), ms.wlog2});
            write_reg(CFG_MAP_HEIGHT, ms.height);
            if (s % 4 == 3) begin
                write_reg(CFG_SPARE_2, 7'($urandom_range(0, 127)));
                write_reg(CFG_SPARE_3, 7'($urandom_range(0, 127)));
            end
            n_settings++;

            // pick the busy window and the pixel palette for this map
            w      = 1 << map_shift();
            h      = int'(cur_height);
            win_w  = (w < 8) ? w : 8;
            win_h  = (h == 0) ? 1 : ((h < 8) ? h : 8);
            win_x0 = $urandom_range(0, w - win_w);
            win_y0 = (h == 0) ? 0 : $urandom_range(0, h - win_h);
            for (int i = 0; i < 3; i++) palette[i] = 8'($urandom_range(0, 255));

            target = n_items + int'(ms.n_items);
            k      = 0;
            while (n_items < target) begin
                k++;
                steady = (k >= 30 && k < 45);
                if (s == 0 && k == 20) hold_req = 1'b1;
                if (s == N_SETTINGS - 2 && k == 25) begin
                    pause_items();
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                offer_item(draw_item());
            end
            steady = 1'b0;
        end

        pause_items();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d items (%0d loads, %0d scans, %0d reads) over %0d map settings",
                 n_items, n_loads, n_scans, n_reads, n_settings);
        $display("Checked %0d results, %0d of them hits, %0d failures",
                 n_results, n_found, n_errors);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #10ms;
        $display("TIMEOUT: %0d results still owed", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
design/tmds_pkg.sv
design/tmds_ifs.sv
design/tmds_ram.sv
design/tmds_engine.sv
design/tile_map_directional_scan.sv
tb/sv/testbench.sv
